### src/rres_pkg.sv
// Shared types and constants for the round-robin endpoint selector.
// Used by rres_pin_table, rres_decide and round_robin_endpoint_selector.
`default_nettype none

package rres_pkg;

	localparam int MAX_EPS     = 8;
	localparam int PIN_ENTRIES = 256;
	localparam int EP_W        = $clog2(MAX_EPS);
	localparam int KEY_W       = $clog2(PIN_ENTRIES);
	localparam int CNT_W       = 4;
	localparam int CFG_DATA_W  = 4;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CNT_W-1:0] EPS_LIMIT = CNT_W'(MAX_EPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_EPS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MODE = 1'd1;

	// Segment kinds; the unused code behaves like a first segment.
	localparam logic [1:0] SEG_FIRST  = 2'd0;
	localparam logic [1:0] SEG_MIDDLE = 2'd1;
	localparam logic [1:0] SEG_LAST   = 2'd2;

	typedef struct packed {
		logic              has_packet;
		logic              is_ctrl_segment;
		logic [1:0]        segment_kind;
		logic [KEY_W-1:0]  message_id;
		logic [MAX_EPS-1:0] connected_mask;
		logic [MAX_EPS-1:0] idle_mask;
	} req_t;

	typedef struct packed {
		logic [EP_W-1:0] ep_index;
		logic            connect_request;
		logic [EP_W-1:0] connect_index;
	} res_t;

	// Pin table update issued by the decision stage.
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [KEY_W-1:0] addr;
		logic [EP_W-1:0]  ep;
	} pin_wr_t;

	// Pin table lookup result seen by the decision stage.
	typedef struct packed {
		logic            valid;
		logic [EP_W-1:0] ep;
	} pin_rd_t;

endpackage

`default_nettype wire

### src/rres_pin_table.sv
// Pin table: per-message endpoint memory with valid flags cleared at reset.
// Depends on rres_pkg for widths and the lookup/update structs.
`default_nettype none

module rres_pin_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [rres_pkg::KEY_W-1:0] rd_addr,
	input  wire logic [rres_pkg::KEY_W-1:0] lk_addr,
	input  wire rres_pkg::pin_wr_t          wr,
	output rres_pkg::pin_rd_t               rd
);
	import rres_pkg::*;

	logic [EP_W-1:0]        mem [PIN_ENTRIES];
	logic [PIN_ENTRIES-1:0] valid_q;
	logic [EP_W-1:0]        rdata_q;
	logic                   hit_q;
	logic [EP_W-1:0]        fwd_q;

	always_ff @(posedge clk) begin
		if (wr.set) begin
			mem[wr.addr] <= wr.ep;
		end
		rdata_q <= mem[rd_addr];
		fwd_q   <= wr.ep;
	end

	// A write landing on the same edge as the read is forwarded next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr.set) begin
				valid_q[wr.addr] <= 1'b1;
			end else if (wr.clr) begin
				valid_q[wr.addr] <= 1'b0;
			end
			hit_q <= wr.set && (wr.addr == rd_addr);
		end
	end

	assign rd.valid = valid_q[lk_addr];
	assign rd.ep    = hit_q ? fwd_q : rdata_q;

endmodule

`default_nettype wire

### src/rres_decide.sv
// Decision stage: round-robin cursor, pin reuse and connect requests.
// Depends on rres_pkg for the request, result and pin table structs.
`default_nettype none

module rres_decide (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_s1,
	input  wire rres_pkg::req_t             req_s1,
	input  wire logic [rres_pkg::CNT_W-1:0] num_eps,
	input  wire logic                       single_mode,
	input  wire rres_pkg::pin_rd_t          pin,
	output rres_pkg::pin_wr_t               pin_wr,
	output rres_pkg::res_t                  res
);
	import rres_pkg::*;

	logic [EP_W-1:0]  cursor_q;
	logic [CNT_W-1:0] eff;
	logic             active;
	logic             is_mid;
	logic             is_first;
	logic             pin_ok;
	logic             take_step;
	logic             multi;
	logic [EP_W-1:0]  cur;
	logic [CNT_W-1:0] nxt;
	logic [EP_W-1:0]  cursor_next;
	logic [EP_W-1:0]  step_sel;
	logic             step_req;

	always_comb begin
		eff      = (num_eps > EPS_LIMIT) ? EPS_LIMIT : num_eps;
		multi    = eff > CNT_W'(1);
		active   = valid_s1 && !single_mode;
		is_mid   = req_s1.has_packet && req_s1.is_ctrl_segment &&
			((req_s1.segment_kind == SEG_MIDDLE) || (req_s1.segment_kind == SEG_LAST));
		is_first = req_s1.has_packet && req_s1.is_ctrl_segment && !is_mid;
		pin_ok   = pin.valid && ({1'b0, pin.ep} < eff);
		take_step = active && (!req_s1.has_packet || (is_mid && !pin_ok));

		// A cursor at or past the count restarts at slot one.
		cur         = ({1'b0, cursor_q} >= eff) ? EP_W'(1) : cursor_q;
		nxt         = {1'b0, cur} + CNT_W'(1);
		cursor_next = (nxt >= eff) ? EP_W'(1) : nxt[EP_W-1:0];

		step_sel = '0;
		step_req = 1'b0;
		if (multi) begin
			if (req_s1.connected_mask[cur]) begin
				step_sel = cur;
			end else begin
				step_req = req_s1.idle_mask[cur];
			end
		end

		res.ep_index        = '0;
		res.connect_request = 1'b0;
		res.connect_index   = '0;
		if (take_step) begin
			res.ep_index        = step_sel;
			res.connect_request = step_req;
			res.connect_index   = step_req ? cur : '0;
		end else if (active && is_mid && pin_ok) begin
			res.ep_index = pin.ep;
		end

		pin_wr.set  = take_step && is_mid;
		pin_wr.clr  = active && is_first;
		pin_wr.addr = req_s1.message_id;
		pin_wr.ep   = step_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= EP_W'(1);
		end else if (take_step && multi) begin
			cursor_q <= cursor_next;
		end
	end

endmodule

`default_nettype wire

### src/round_robin_endpoint_selector.sv
// Top level of the round-robin endpoint selector with per-message pinning.
// Depends on rres_pkg, rres_pin_table and rres_decide.
//
// Usage: raise start with the request fields for one cycle; a request is
// transferred at each rising edge where start is high and busy is low.
// busy never rises, so a new request may be transferred every cycle.
// Each request yields exactly one result, shown on ep_index, connect_request
// and connect_index for one cycle while done is high. The request passes the
// input register, decision logic and result register. The receiver cannot
// stall; results must be taken in the cycle they appear. Throughput is one
// request per cycle, set by the single pin table read port, whose read is
// started at the transfer edge and patched by forwarding when the previous
// request pinned the same message. Configuration (num_eps at index 0,
// single_mode at index 1) is written via cfg_wr_en/cfg_index/cfg_wdata, by
// the user only while no request is in flight, not enforced by the block.
// Reset clears every pin at once through per-entry valid flags, sets the
// cursor to slot one, num_eps to one and single_mode to zero; no clearing
// pass is needed, so requests are taken from the first cycle after reset.
`default_nettype none

module round_robin_endpoint_selector (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            has_packet,
	input  wire logic                            is_ctrl_segment,
	input  wire logic [1:0]                      segment_kind,
	input  wire logic [7:0]                      message_id,
	input  wire logic [7:0]                      connected_mask,
	input  wire logic [7:0]                      idle_mask,
	input  wire logic                            cfg_wr_en,
	input  wire logic [rres_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rres_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                                 done,
	output logic [2:0]                           ep_index,
	output logic                                 connect_request,
	output logic [2:0]                           connect_index
);
	import rres_pkg::*;

	logic             accept;
	req_t             req_in;
	req_t             req_s1;
	logic             valid_s1;
	res_t             res_s1;
	res_t             res_s2;
	logic             done_s2;
	logic [CNT_W-1:0] num_eps_q;
	logic             single_mode_q;
	pin_wr_t          pin_wr;
	pin_rd_t          pin_rd;

	// The block never holds off a request.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign req_in.has_packet      = has_packet;
	assign req_in.is_ctrl_segment = is_ctrl_segment;
	assign req_in.segment_kind    = segment_kind;
	assign req_in.message_id      = message_id;
	assign req_in.connected_mask  = connected_mask;
	assign req_in.idle_mask       = idle_mask;

	// Configuration registers; writes are taken immediately.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_eps_q     <= CNT_W'(1);
			single_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NUM_EPS:     num_eps_q     <= cfg_wdata;
				REG_SINGLE_MODE: single_mode_q <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	// Input register. The pin table read for the same request starts here too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
		end
	end

	rres_pin_table u_pin_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (message_id),
		.lk_addr (req_s1.message_id),
		.wr      (pin_wr),
		.rd      (pin_rd)
	);

	rres_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.req_s1      (req_s1),
		.num_eps     (num_eps_q),
		.single_mode (single_mode_q),
		.pin         (pin_rd),
		.pin_wr      (pin_wr),
		.res         (res_s1)
	);

	// Result register: each result is shown for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_s1;
		end
	end

	assign done            = done_s2;
	assign ep_index        = res_s2.ep_index;
	assign connect_request = res_s2.connect_request;
	assign connect_index   = res_s2.connect_index;

endmodule

`default_nettype wire
